// ===== rtl/core/sirb_pkg.sv =====
// ============================================================================
// sirb_pkg
// Shared types and constants for the sequence-indexed retransmit buffer.
// ============================================================================
package sirb_pkg;

    localparam int SEQ_W  = 64;   // sequence number width
    localparam int WORD_W = 64;   // payload port width
    localparam int FILL_W = 11;   // fill count port width

    // request kinds
    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_EXEC
    } state_t;

endpackage

// ===== rtl/core/seq_indexed_retransmit_buffer.sv =====
// ============================================================================
// seq_indexed_retransmit_buffer
// Packet store indexed by sequence number with a sliding retention window.
// ============================================================================
// Each request is either a push (store payload_in in slot seq_num mod
// CAPACITY, tagged with the full sequence number, unless the window is open
// and seq_num lies below window_min) or a lookup (return the stored payload
// if seq_num lies inside [window_min, window_max] and the slot still holds
// that sequence number). Every request yields exactly one response carrying
// the window bounds and fill count after the request. One request is handled
// at a time, in the steps slot index, memory read, execute/write-back and
// return to idle; with a power-of-two CAPACITY the slot index is a mask,
// otherwise it comes from a remainder unit. The registered slot memory read
// sets the read stage. After reset the block sweeps the tag memory to clear
// every valid bit; req_stall stays high until it completes. A finished
// response sits in the output register and a waiting consumer holds off
// only the write-back of the following request.
// ============================================================================
module seq_indexed_retransmit_buffer #(
    parameter int CAPACITY     = 1024,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          req_type,
    input  logic [sirb_pkg::SEQ_W-1:0]    seq_num,
    input  logic [sirb_pkg::WORD_W-1:0]   payload_in,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          push_accepted,
    output logic                          lookup_hit,
    output logic [sirb_pkg::WORD_W-1:0]   payload_out,
    output logic [sirb_pkg::SEQ_W-1:0]    window_min,
    output logic [sirb_pkg::SEQ_W-1:0]    window_max,
    output logic [sirb_pkg::FILL_W-1:0]   fill_count
);
    import sirb_pkg::*;

    localparam int IW = $clog2(CAPACITY);       // slot index width
    localparam int SW = $clog2(CAPACITY + 1);   // span counter width

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic   req_fire;
    logic   rsp_free;           // output register can take a new response
    logic   exec_go;            // execute stage commits this cycle

    logic [IW-1:0] clr_addr_reg;

    // latched request
    logic                    type_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    // slot index
    logic          idx_done;
    logic [IW-1:0] idx;

    // window
    logic             started_reg;
    logic [SEQ_W-1:0] low_reg;
    logic [SEQ_W-1:0] high_reg;
    logic [SW-1:0]    span_reg;

    // precomputed compares and differences
    logic             ge_low_reg;
    logic             gt_high_reg;
    logic [SEQ_W-1:0] diff_reg;      // new high minus low
    logic [SEQ_W-1:0] cut_low_reg;   // seq - CAPACITY + 1

    // slot memories: tag memory holds {valid, tag}
    logic [SEQ_W:0]          tag_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];
    logic [SEQ_W:0]          tag_rd_reg;
    logic [PAYLOAD_BITS-1:0] pay_rd_reg;
    logic                    tag_we;
    logic [IW-1:0]           tag_waddr;
    logic [SEQ_W:0]          tag_wdata;
    logic                    pay_we;

    // execute results
    logic             is_push;
    logic             push_ok;
    logic             hit;
    logic [SEQ_W-1:0] low_next;
    logic [SEQ_W-1:0] high_next;
    logic [SW-1:0]    span_next;

    // response register
    logic              rsp_valid_reg;
    logic              rsp_acc_reg;
    logic              rsp_hit_reg;
    logic [WORD_W-1:0] rsp_pay_reg;
    logic [SEQ_W-1:0]  rsp_min_reg;
    logic [SEQ_W-1:0]  rsp_max_reg;
    logic [FILL_W-1:0] rsp_fill_reg;

    assign req_fire = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign exec_go  = (state_reg == ST_EXEC) && rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == IW'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                if (idx_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (state_reg == ST_CLEAR)
        begin
            clr_addr_reg <= clr_addr_reg + IW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Request latch and slot index
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            type_reg <= req_type;
            seq_reg  <= seq_num;
            pay_reg  <= payload_in[PAYLOAD_BITS-1:0];
        end
    end

    sirb_slot_index #(
        .CAPACITY (CAPACITY)
    ) u_slot_index (
        .clk   (clk),
        .rst_n (rst_n),
        .start (req_fire),
        .seq   (seq_num),
        .done  (idx_done),
        .idx   (idx)
    );

    // Window compares during indexing, span difference in the read cycle.
    // Window registers only move in execute, so these stay coherent.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INDEX)
        begin
            ge_low_reg  <= (seq_reg >= low_reg);
            gt_high_reg <= (seq_reg > high_reg);
        end
        if (state_reg == ST_READ)
        begin
            diff_reg    <= (gt_high_reg ? seq_reg : high_reg) - low_reg;
            cut_low_reg <= seq_reg - SEQ_W'(CAPACITY - 1);
        end
    end

    // ------------------------------------------------------------------
    // Slot memories; read address is the current index every cycle
    // ------------------------------------------------------------------
    assign tag_we    = (state_reg == ST_CLEAR) || (exec_go && push_ok);
    assign tag_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx;
    assign tag_wdata = (state_reg == ST_CLEAR) ? '0 : {1'b1, seq_reg};
    assign pay_we    = exec_go && push_ok;

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rd_reg <= tag_mem[idx];
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[idx] <= pay_reg;
        end
        pay_rd_reg <= pay_mem[idx];
    end

    // ------------------------------------------------------------------
    // Execute: window update and lookup match
    // ------------------------------------------------------------------
    assign is_push = (type_reg == REQ_PUSH);
    assign push_ok = is_push && (!started_reg || ge_low_reg);
    assign hit     = (type_reg == REQ_LOOKUP) && started_reg && ge_low_reg
                     && !gt_high_reg && tag_rd_reg[SEQ_W]
                     && (tag_rd_reg[SEQ_W-1:0] == seq_reg);

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        span_next = span_reg;
        if (push_ok)
        begin
            if (!started_reg)
            begin
                // first push opens the window
                low_next  = seq_reg;
                high_next = seq_reg;
                span_next = SW'(1);
            end
            else
            begin
                if (gt_high_reg)
                begin
                    high_next = seq_reg;
                end
                if (diff_reg >= SEQ_W'(CAPACITY))
                begin
                    // window too wide: drag the low edge up
                    low_next  = cut_low_reg;
                    span_next = SW'(CAPACITY);
                end
                else
                begin
                    span_next = diff_reg[SW-1:0] + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            low_reg     <= '0;
            high_reg    <= '0;
            span_reg    <= '0;
        end
        else if (exec_go)
        begin
            started_reg <= started_reg || push_ok;
            low_reg     <= low_next;
            high_reg    <= high_next;
            span_reg    <= span_next;
        end
    end

    // ------------------------------------------------------------------
    // Response register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            rsp_acc_reg  <= push_ok;
            rsp_hit_reg  <= hit;
            rsp_pay_reg  <= hit ? WORD_W'(pay_rd_reg) : '0;
            rsp_min_reg  <= low_next;
            rsp_max_reg  <= high_next;
            rsp_fill_reg <= FILL_W'(span_next);
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign push_accepted = rsp_acc_reg;
    assign lookup_hit    = rsp_hit_reg;
    assign payload_out   = rsp_pay_reg;
    assign window_min    = rsp_min_reg;
    assign window_max    = rsp_max_reg;
    assign fill_count    = rsp_fill_reg;

endmodule

// ===== rtl/core/sirb_slot_index.sv =====
// ============================================================================
// sirb_slot_index
// Reduces a sequence number to its slot index, seq mod CAPACITY.
// Power-of-two capacity: a registered mask. Otherwise a remainder unit that
// consumes eight bits of the sequence number per cycle.
// ============================================================================
module sirb_slot_index #(
    parameter int CAPACITY = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sirb_pkg::SEQ_W-1:0]   seq,
    output logic                         done,
    output logic [$clog2(CAPACITY)-1:0]  idx
);
    import sirb_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam bit POW2 = (CAPACITY == (1 << IW));

    generate
        if (POW2) begin : g_mask
            logic          done_reg;
            logic [IW-1:0] idx_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    idx_reg <= seq[IW-1:0];
                end
            end

            assign done = done_reg;
            assign idx  = idx_reg;
        end
        else begin : g_divide
            localparam int BPC    = 8;              // bits per cycle
            localparam int CYCLES = SEQ_W / BPC;
            localparam int CW     = $clog2(CYCLES);

            logic             busy_reg;
            logic             done_reg;
            logic [CW-1:0]    cnt_reg;
            logic [SEQ_W-1:0] sh_reg;
            logic [IW-1:0]    rem_reg;
            logic [IW-1:0]    rem_next;

            // rem <- (2*rem + bit) mod CAPACITY; rem < CAPACITY so one subtract
            always_comb
            begin
                logic [IW:0] t;
                rem_next = rem_reg;
                for (int i = 0; i < BPC; i++)
                begin
                    t = {rem_next, sh_reg[SEQ_W-1-i]};
                    if (t >= (IW+1)'(CAPACITY))
                    begin
                        t = t - (IW+1)'(CAPACITY);
                    end
                    rem_next = t[IW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end
                    else if (busy_reg)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        if (cnt_reg == CW'(CYCLES - 1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    sh_reg  <= seq;
                    rem_reg <= '0;
                end
                else if (busy_reg)
                begin
                    sh_reg  <= sh_reg << BPC;
                    rem_reg <= rem_next;
                end
            end

            assign done = done_reg;
            assign idx  = rem_reg;
        end
    endgenerate

endmodule

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top - sequence-indexed retransmit buffer testbench
// Drives push and lookup requests into the buffer and checks every response
// against a cycle-free software copy of the slot store and sliding window.
// A short table of hand-picked requests comes first, then window-relative
// random traffic under three stall mixes, then a few rows at the top of the
// 64-bit sequence range, which close the run since the window never moves
// back down.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sirb_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int PAYLOAD_BITS = 64;

    localparam logic [WORD_W-1:0] PAY_MASK = {WORD_W{1'b1}} >> (WORD_W - PAYLOAD_BITS);
    localparam logic [SEQ_W-1:0]  SEQ_TOP  = {SEQ_W{1'b1}};

    // Longest stretch with no handshake on either side: the clearing sweep
    // after reset dominates over a request plus its stall streaks. Taken
    // several times over.
    localparam int QUIET_LIMIT  = 4 * CAPACITY + 4000;
    // Settling time after the last response.
    localparam int DRAIN_CYCLES = 24;
    localparam int RAND_PER_PHASE = 650;

    // ------------------------------------------------------------------------
    // Response record and request table
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic              accepted;
        logic              hit;
        logic [WORD_W-1:0] pay_out;
        logic [SEQ_W-1:0]  wmin;
        logic [SEQ_W-1:0]  wmax;
        logic [FILL_W-1:0] fill;
    } rsp_t;

    typedef struct packed {
        logic              req_kind;
        logic [SEQ_W-1:0]  seq;
        logic [WORD_W-1:0] word;
        logic              typed;    // row carries its own expected response
        rsp_t              rsp;
    } req_row_t;

    localparam rsp_t NO_RSP = '0;

    localparam int OPEN_ROWS = 21;   // rows run before the random part
    localparam int N_ROWS    = 26;   // all rows; those past OPEN_ROWS run after it, at the range top

    localparam req_row_t REQ_ROWS [N_ROWS] = '{
        // lookups before the first push: all zero
        '{REQ_LOOKUP, 64'd0, 64'd0, 1'b1, NO_RSP},
        '{REQ_LOOKUP, SEQ_TOP, {64{1'b1}}, 1'b1, NO_RSP},
        // first push opens the window at 0
        '{REQ_PUSH, 64'd0, {64{1'b1}}, 1'b1,
          '{1'b1, 1'b0, 64'd0, 64'd0, 64'd0, 11'd1}},
        '{REQ_LOOKUP, 64'd0, 64'd0, 1'b1,
          '{1'b0, 1'b1, {64{1'b1}}, 64'd0, 64'd0, 11'd1}},
        // just above the window
        '{REQ_LOOKUP, 64'd1, 64'd0, 1'b1,
          '{1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 11'd1}},
        // window fills exactly to capacity
        '{REQ_PUSH, 64'd1023, 64'd0, 1'b1,
          '{1'b1, 1'b0, 64'd0, 64'd0, 64'd1023, 11'd1024}},
        // in window, slot never written
        '{REQ_LOOKUP, 64'd512, 64'd0, 1'b1,
          '{1'b0, 1'b0, 64'd0, 64'd0, 64'd1023, 11'd1024}},
        // one past capacity: minimum slides up
        '{REQ_PUSH, 64'd1024, 64'h5555_5555_5555_5555, 1'b1,
          '{1'b1, 1'b0, 64'd0, 64'd1, 64'd1024, 11'd1024}},
        '{REQ_LOOKUP, 64'd0, 64'd0, 1'b1,
          '{1'b0, 1'b0, 64'd0, 64'd1, 64'd1024, 11'd1024}},
        '{REQ_LOOKUP, 64'd1024, 64'd0, 1'b1,
          '{1'b0, 1'b1, 64'h5555_5555_5555_5555, 64'd1, 64'd1024, 11'd1024}},
        // below the minimum: dropped
        '{REQ_PUSH, 64'd0, {64{1'b1}}, 1'b1,
          '{1'b0, 1'b0, 64'd0, 64'd1, 64'd1024, 11'd1024}},
        // overwrite inside the window, window unchanged
        '{REQ_PUSH, 64'd1023, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RSP},
        '{REQ_LOOKUP, 64'd1023, 64'd0, 1'b0, NO_RSP},
        '{REQ_LOOKUP, 64'd2048, 64'd0, 1'b0, NO_RSP},
        // long jump forward
        '{REQ_PUSH, 64'd5000, 64'h0123_4567_89AB_CDEF, 1'b0, NO_RSP},
        '{REQ_LOOKUP, 64'd1024, 64'd0, 1'b0, NO_RSP},
        '{REQ_LOOKUP, 64'd5000, 64'd0, 1'b0, NO_RSP},
        '{REQ_LOOKUP, 64'd4000, 64'd0, 1'b0, NO_RSP},
        // same slot as 5000, one lap on
        '{REQ_PUSH, 64'd6024, 64'hFEDC_BA98_7654_3210, 1'b0, NO_RSP},
        '{REQ_LOOKUP, 64'd5000, 64'd0, 1'b0, NO_RSP},
        // in window, slot valid but holds a stale sequence number
        '{REQ_LOOKUP, 64'd5120, 64'd0, 1'b0, NO_RSP},
        // --- top of the sequence range ---
        '{REQ_PUSH, SEQ_TOP, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1,
          '{1'b1, 1'b0, 64'd0, 64'hFFFF_FFFF_FFFF_FC00, SEQ_TOP, 11'd1024}},
        '{REQ_LOOKUP, SEQ_TOP, 64'd0, 1'b1,
          '{1'b0, 1'b1, 64'h0F0F_0F0F_0F0F_0F0F, 64'hFFFF_FFFF_FFFF_FC00, SEQ_TOP,
            11'd1024}},
        '{REQ_PUSH, 64'hFFFF_FFFF_FFFF_FFFE, 64'h3C3C_3C3C_3C3C_3C3C, 1'b0, NO_RSP},
        '{REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FBFF, 64'd0, 1'b0, NO_RSP},
        '{REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1'b0, NO_RSP}
    };

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic              req_type;
    logic [SEQ_W-1:0]  seq_num;
    logic [WORD_W-1:0] payload_in;
    logic              rsp_valid;
    logic              rsp_stall;
    logic              push_accepted;
    logic              lookup_hit;
    logic [WORD_W-1:0] payload_out;
    logic [SEQ_W-1:0]  window_min;
    logic [SEQ_W-1:0]  window_max;
    logic [FILL_W-1:0] fill_count;

    seq_indexed_retransmit_buffer #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .seq_num       (seq_num),
        .payload_in    (payload_in),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .push_accepted (push_accepted),
        .lookup_hit    (lookup_hit),
        .payload_out   (payload_out),
        .window_min    (window_min),
        .window_max    (window_max),
        .fill_count    (fill_count)
    );

    // 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the slot store and window
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0] shadow_word [CAPACITY];
    logic [SEQ_W-1:0]  shadow_seq  [CAPACITY];
    bit                shadow_live [CAPACITY];    // all clear, as after reset
    logic [SEQ_W-1:0]  lo_mark  = '0;
    logic [SEQ_W-1:0]  hi_mark  = '0;
    logic [SEQ_W-1:0]  span_cnt = '0;
    bit                opened   = 1'b0;

    rsp_t rsp_due [$];    // responses still owed by the block, oldest first

    int unsigned src_gap_pct = 0;
    int unsigned snk_gap_pct = 0;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          n_stored = 0, n_dropped = 0, n_hits = 0, n_misses = 0;

    // Applies one request to the shadow store and returns the response the
    // block owes for it.
    function automatic rsp_t retx_step(logic kind, logic [SEQ_W-1:0] seq,
                                       logic [WORD_W-1:0] word);
        rsp_t             r;
        int unsigned      slot;
        logic [SEQ_W-1:0] span;
        r    = '0;
        slot = int'(seq % SEQ_W'(CAPACITY));
        if (kind == REQ_PUSH)
        begin
            if (!opened || seq >= lo_mark)
            begin
                shadow_word[slot] = word & PAY_MASK;
                shadow_seq[slot]  = seq;
                shadow_live[slot] = 1'b1;
                r.accepted = 1'b1;
                n_stored++;
                if (!opened)
                begin
                    opened   = 1'b1;
                    lo_mark  = seq;
                    hi_mark  = seq;
                    span_cnt = 1;
                end
                else
                begin
                    if (seq > hi_mark)
                        hi_mark = seq;
                    // difference, not difference plus one: safe over the full range
                    span = hi_mark - lo_mark;
                    if (span >= SEQ_W'(CAPACITY))
                    begin
                        lo_mark  = hi_mark - SEQ_W'(CAPACITY) + 1;
                        span_cnt = SEQ_W'(CAPACITY);
                    end
                    else
                        span_cnt = span + 1;
                end
            end
            else
                n_dropped++;
        end
        else if (opened && seq >= lo_mark && seq <= hi_mark &&
                 shadow_live[slot] && shadow_seq[slot] == seq)
        begin
            r.hit     = 1'b1;
            r.pay_out = shadow_word[slot] & PAY_MASK;
            n_hits++;
        end
        else
            n_misses++;
        r.wmin = opened ? lo_mark : '0;
        r.wmax = opened ? hi_mark : '0;
        r.fill = opened ? span_cnt[FILL_W-1:0] : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Presents one request from the falling edge, with a random run of idle
    // cycles ahead of it, and holds it until the block takes it. The owed
    // response is queued at the accepting edge; a table row with its own
    // expectation queues that instead, though the shadow still steps.
    task automatic send_request(input logic kind, input logic [SEQ_W-1:0] seq,
                                input logic [WORD_W-1:0] word, input logic typed,
                                input rsp_t typed_rsp);
        rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        seq_num    <= seq;
        payload_in <= word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = retx_step(kind, seq, word);
        rsp_due.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic walk_rows(input int first, input int last);
        int i;
        for (i = first; i <= last; i++)
            send_request(REQ_ROWS[i].req_kind, REQ_ROWS[i].seq, REQ_ROWS[i].word,
                         REQ_ROWS[i].typed, REQ_ROWS[i].rsp);
    endtask

    initial
    begin : stimulus
        int               phase;
        int               n;
        int unsigned      pick;
        int unsigned      spread;
        int unsigned      back;
        logic             kind;
        logic [SEQ_W-1:0] seq;
        logic [WORD_W-1:0] word;

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_type   = REQ_PUSH;
        seq_num    = '0;
        payload_in = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hand-picked rows: empty buffer, first push, the window filling,
        // sliding, drops, overwrites, stale tags. The block holds off
        // requests during its clearing sweep, so no wait is needed here.
        src_gap_pct = 22;
        snk_gap_pct = 48;
        walk_rows(0, OPEN_ROWS - 1);

        // Random traffic steered by the current window, so most requests land
        // where the window moves or the slots hold live data.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin src_gap_pct = 22; snk_gap_pct = 48; end
                1:       begin src_gap_pct = 48; snk_gap_pct = 22; end
                default: begin src_gap_pct = 0;  snk_gap_pct = 0;  end
            endcase
            for (n = 0; n < RAND_PER_PHASE; n++)
            begin
                spread = 32'(hi_mark - lo_mark);
                pick   = $urandom_range(0, 99);
                back   = $urandom_range(1, 2048);
                word   = {$urandom, $urandom};
                kind   = (pick < 53) ? REQ_PUSH : REQ_LOOKUP;
                if (pick < 35)
                    // creep the top of the window forward
                    seq = hi_mark + SEQ_W'($urandom_range(0, 4));
                else if (pick < 45)
                    seq = lo_mark + SEQ_W'($urandom_range(0, spread));
                else if (pick < 50)
                    // behind the window: dropped, or just above it when the window sits too low
                    seq = (lo_mark >= SEQ_W'(back)) ? lo_mark - SEQ_W'(back) : hi_mark + 1;
                else if (pick < 53)
                    // leap 1000 to 3000 past the top of the window
                    seq = hi_mark + SEQ_W'($urandom_range(1000, 3000));
                else if (pick < 90)
                    seq = lo_mark + SEQ_W'($urandom_range(0, spread));
                else if (pick < 96)
                    seq = pick[0] ? hi_mark + SEQ_W'(back)
                        : (lo_mark >= SEQ_W'(back)) ? lo_mark - SEQ_W'(back) : hi_mark + 1;
                else
                    seq = {$urandom, $urandom};
                send_request(kind, seq, word, 1'b0, NO_RSP);
            end
        end

        // top of the sequence range, last since the window cannot come back
        walk_rows(OPEN_ROWS, N_ROWS - 1);

        @(negedge clk);
        req_valid <= 1'b0;

        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d pushes stored, %0d dropped, %0d hits, %0d misses,",
                 n_stored + n_dropped + n_hits + n_misses, n_stored, n_dropped, n_hits,
                 n_misses);
        $display("with the window walked up to the top of the sequence range.");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------
    initial
    begin : sink_stall
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall <= ($urandom_range(0, 99) < snk_gap_pct);
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = rsp_due.pop_front();
                check_field("push_accepted", 64'(want.accepted), 64'(push_accepted));
                check_field("lookup_hit", 64'(want.hit), 64'(lookup_hit));
                check_field("payload_out", want.pay_out, payload_out);
                check_field("window_min", want.wmin, window_min);
                check_field("window_max", want.wmax, window_max);
                check_field("fill_count", 64'(want.fill), 64'(fill_count));
            end
        end
    end

    // Hang guard: too long without a handshake on either side
    always @(posedge clk)
    begin
        if ((req_valid === 1'b1 && req_stall === 1'b0) ||
            (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
